@@ src/lrcf_pkg.sv @@
// ----------------------------------------------------------------------------
// lrcf_pkg
// Shared constants, codes and types of the RGBW cross-fade engine.
// ----------------------------------------------------------------------------
package lrcf_pkg;

   localparam int NUM_LEDS = 64;
   localparam int LED_AW   = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

   localparam logic [31:0] RESET_MIN_COLOR = 32'h0000_0000;
   localparam logic [31:0] RESET_MAX_COLOR = 32'hFFFF_FFFF;
   localparam logic [15:0] RESET_MIN_TICKS = 16'd30;
   localparam logic [15:0] RESET_MAX_TICKS = 16'd300;
   localparam logic [15:0] RESET_END_TICK  = 16'hFFFF;

   // Configuration register indexes.
   localparam logic [1:0] CSR_MIN_COLOR = 2'd0;
   localparam logic [1:0] CSR_MAX_COLOR = 2'd1;
   localparam logic [1:0] CSR_MIN_TICKS = 2'd2;
   localparam logic [1:0] CSR_MAX_TICKS = 2'd3;

   // Request operations.
   localparam logic OP_ADVANCE = 1'b0;
   localparam logic OP_INIT    = 1'b1;

   // Draw slots and interpolation lanes.
   localparam logic [2:0] DRAW_RED    = 3'd0;
   localparam logic [2:0] DRAW_GREEN  = 3'd1;
   localparam logic [2:0] DRAW_BLUE   = 3'd2;
   localparam logic [2:0] DRAW_WHITE  = 3'd3;
   localparam logic [2:0] DRAW_TICKS  = 3'd4;
   localparam logic [2:0] LAST_LANE   = 3'd3;

   // Divider: 32-bit dividend, 16-bit divisor, four quotient bits a cycle.
   localparam int DIV_BITS_PER_CYCLE = 4;
   localparam int DIV_CYCLES         = 32 / DIV_BITS_PER_CYCLE;
   localparam int DIV_CNT_W          = $clog2(DIV_CYCLES);

   typedef struct packed {
      logic [31:0] start_color;
      logic [31:0] target_color;
      logic [15:0] step_count;
      logic [15:0] end_tick;
      logic [31:0] current_color;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic       accept;
      logic       load;
      logic       mul;
      logic       div_start;
      logic       draw;
      logic [2:0] idx;
      logic       capture;
      logic       retarget;
      logic       write;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic in_range;
      logic op_init;
      logic cnt_at_end;
      logic div_done;
   } status_type;

endpackage

@@ src/lrcf_ram.sv @@
// ----------------------------------------------------------------------------
// lrcf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lrcf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

@@ src/lrcf_divider.sv @@
// ----------------------------------------------------------------------------
// lrcf_divider
// Iterative unsigned divider, 32-bit dividend by 16-bit divisor.
// Retires four quotient bits a cycle and pulses done for one cycle.
// ----------------------------------------------------------------------------
module lrcf_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [15:0] divisor,
   output logic [31:0] quotient,
   output logic [15:0] remainder,
   output logic        done
);

   logic [31:0] dvd_ff, dvd_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] dsr_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [lrcf_pkg::DIV_CNT_W-1:0] cnt_ff;

   // Restoring steps; the dividend register fills with quotient bits from below.
   always_comb begin
      logic [16:0] trial;
      logic [31:0] d;
      logic [15:0] r;
      d = dvd_ff;
      r = rem_ff;
      for (int i = 0; i < lrcf_pkg::DIV_BITS_PER_CYCLE; i++) begin
         trial = {r, d[31]};
         if (trial >= {1'b0, dsr_ff}) begin
            trial = trial - {1'b0, dsr_ff};
            d     = {d[30:0], 1'b1};
         end else begin
            d     = {d[30:0], 1'b0};
         end
         r = trial[15:0];
      end
      dvd_in = d;
      rem_in = r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            dvd_ff  <= dividend;
            rem_ff  <= '0;
            dsr_ff  <= divisor;
         end else if (busy_ff) begin
            dvd_ff <= dvd_in;
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == lrcf_pkg::DIV_CNT_W'(lrcf_pkg::DIV_CYCLES - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quotient  = dvd_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

@@ src/lrcf_datapath.sv @@
// ----------------------------------------------------------------------------
// lrcf_datapath
// Per-LED state memory, configuration registers, interpolation and random
// draws around one shared divider, and the response register.
// ----------------------------------------------------------------------------
module lrcf_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  lrcf_pkg::cmd_type    cmd,
   output lrcf_pkg::status_type status,
   input  logic                 req_op,
   input  logic [5:0]           req_led,
   input  logic [31:0]          req_rand_red,
   input  logic [31:0]          req_rand_green,
   input  logic [31:0]          req_rand_blue,
   input  logic [31:0]          req_rand_white,
   input  logic [31:0]          req_rand_ticks,
   input  logic                 csr_wr_en,
   input  logic [1:0]           csr_index,
   input  logic [31:0]          csr_wdata,
   output logic [5:0]           rsp_led_out,
   output logic [31:0]          rsp_color,
   output logic                 rsp_retargeted
);

   logic [31:0] min_color_ff, max_color_ff;
   logic [15:0] min_ticks_ff, max_ticks_ff;

   logic        op_ff;
   logic [5:0]  led_ff;
   logic        in_range_ff;
   logic [31:0] rand_red_ff, rand_green_ff, rand_blue_ff, rand_white_ff, rand_ticks_ff;

   logic [lrcf_pkg::NUM_LEDS-1:0] valid_ff;
   logic                          rd_valid_ff;

   lrcf_pkg::entry_type ent_ff, rd_ent, wr_ent, reset_ent;
   logic [15:0] cnt_ff;
   logic [31:0] color_ff;
   logic [31:0] new_target_ff;
   logic [15:0] new_end_ff;
   logic        retarget_ff;
   logic [23:0] prod_ff;
   logic        neg_ff;

   logic [lrcf_pkg::ENTRY_W-1:0] ram_rdata;
   logic [lrcf_pkg::LED_AW-1:0]  rd_addr, wr_addr;

   logic [31:0] div_quot;
   logic [15:0] div_rem;
   logic        div_done;
   logic [31:0] div_dividend;
   logic [15:0] div_divisor;

   logic [7:0]  lane_s, lane_t;
   logic [7:0]  lane_mag;
   logic [31:0] draw_rand;
   logic [15:0] draw_lo, draw_hi, draw_val;
   logic        draw_open;
   logic [25:0] interp_v;
   logic [7:0]  interp_sat;

   assign rd_addr = lrcf_pkg::LED_AW'(req_led);
   assign wr_addr = lrcf_pkg::LED_AW'(led_ff);

   lrcf_ram #(
      .WIDTH (lrcf_pkg::ENTRY_W),
      .DEPTH (lrcf_pkg::NUM_LEDS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (cmd.write),
      .wr_addr (wr_addr),
      .wr_data (wr_ent),
      .rd_en   (cmd.accept),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   lrcf_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quot),
      .remainder (div_rem),
      .done      (div_done)
   );

   always_comb begin
      reset_ent               = '0;
      reset_ent.end_tick      = lrcf_pkg::RESET_END_TICK;
      rd_ent                  = rd_valid_ff ? lrcf_pkg::entry_type'(ram_rdata) : reset_ent;
   end

   // Interpolation lane operands.
   assign lane_s   = ent_ff.start_color[{cmd.idx[1:0], 3'b000} +: 8];
   assign lane_t   = ent_ff.target_color[{cmd.idx[1:0], 3'b000} +: 8];
   assign lane_mag = (lane_t < lane_s) ? (lane_s - lane_t) : (lane_t - lane_s);

   // Draw operands: config bytes run R,G,B,W from the top byte down.
   always_comb begin
      case (cmd.idx)
         lrcf_pkg::DRAW_RED: begin
            draw_rand = rand_red_ff;
            draw_lo   = {8'd0, min_color_ff[31:24]};
            draw_hi   = {8'd0, max_color_ff[31:24]};
         end
         lrcf_pkg::DRAW_GREEN: begin
            draw_rand = rand_green_ff;
            draw_lo   = {8'd0, min_color_ff[23:16]};
            draw_hi   = {8'd0, max_color_ff[23:16]};
         end
         lrcf_pkg::DRAW_BLUE: begin
            draw_rand = rand_blue_ff;
            draw_lo   = {8'd0, min_color_ff[15:8]};
            draw_hi   = {8'd0, max_color_ff[15:8]};
         end
         lrcf_pkg::DRAW_WHITE: begin
            draw_rand = rand_white_ff;
            draw_lo   = {8'd0, min_color_ff[7:0]};
            draw_hi   = {8'd0, max_color_ff[7:0]};
         end
         default: begin
            draw_rand = rand_ticks_ff;
            draw_lo   = min_ticks_ff;
            draw_hi   = max_ticks_ff;
         end
      endcase
   end

   assign draw_open = draw_hi > draw_lo;
   assign draw_val  = draw_open ? (draw_lo + div_rem) : draw_lo;

   always_comb begin
      if (cmd.draw) begin
         div_dividend = draw_rand;
         div_divisor  = draw_open ? (draw_hi - draw_lo) : 16'd1;
      end else begin
         div_dividend = {8'd0, prod_ff};
         div_divisor  = (ent_ff.end_tick == 16'd0) ? 16'd1 : ent_ff.end_tick;
      end
   end

   // Quotient truncates toward zero, so the sign is applied after dividing.
   always_comb begin
      interp_v = neg_ff ? ({18'd0, lane_s} - {2'd0, div_quot[23:0]})
                        : ({18'd0, lane_s} + {2'd0, div_quot[23:0]});
      if (interp_v[25]) begin
         interp_sat = 8'd0;
      end else if (interp_v > 26'd255) begin
         interp_sat = 8'hFF;
      end else begin
         interp_sat = interp_v[7:0];
      end
   end

   always_comb begin
      wr_ent               = ent_ff;
      wr_ent.current_color = color_ff;
      wr_ent.step_count    = cnt_ff;
      if (retarget_ff) begin
         wr_ent.start_color  = color_ff;
         wr_ent.target_color = new_target_ff;
         wr_ent.end_tick     = new_end_ff;
         wr_ent.step_count   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_color_ff <= lrcf_pkg::RESET_MIN_COLOR;
         max_color_ff <= lrcf_pkg::RESET_MAX_COLOR;
         min_ticks_ff <= lrcf_pkg::RESET_MIN_TICKS;
         max_ticks_ff <= lrcf_pkg::RESET_MAX_TICKS;
         valid_ff     <= '0;
         retarget_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               lrcf_pkg::CSR_MIN_COLOR: min_color_ff <= csr_wdata;
               lrcf_pkg::CSR_MAX_COLOR: max_color_ff <= csr_wdata;
               lrcf_pkg::CSR_MIN_TICKS: min_ticks_ff <= csr_wdata[15:0];
               lrcf_pkg::CSR_MAX_TICKS: max_ticks_ff <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (cmd.write) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (cmd.accept) begin
            retarget_ff <= 1'b0;
         end else if (cmd.retarget) begin
            retarget_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff         <= req_op;
         led_ff        <= req_led;
         in_range_ff   <= 32'(req_led) < lrcf_pkg::NUM_LEDS;
         rand_red_ff   <= req_rand_red;
         rand_green_ff <= req_rand_green;
         rand_blue_ff  <= req_rand_blue;
         rand_white_ff <= req_rand_white;
         rand_ticks_ff <= req_rand_ticks;
         rd_valid_ff   <= valid_ff[rd_addr];
      end
      if (cmd.load) begin
         ent_ff   <= rd_ent;
         cnt_ff   <= rd_ent.step_count + 16'd1;
         color_ff <= rd_ent.current_color;
      end
      if (cmd.mul) begin
         prod_ff <= 24'(lane_mag) * 24'(cnt_ff);
         neg_ff  <= lane_t < lane_s;
      end
      if (cmd.capture) begin
         if (cmd.draw) begin
            case (cmd.idx)
               lrcf_pkg::DRAW_RED:   new_target_ff[23:16] <= draw_val[7:0];
               lrcf_pkg::DRAW_GREEN: new_target_ff[15:8]  <= draw_val[7:0];
               lrcf_pkg::DRAW_BLUE:  new_target_ff[7:0]   <= draw_val[7:0];
               lrcf_pkg::DRAW_WHITE: new_target_ff[31:24] <= draw_val[7:0];
               default:              new_end_ff           <= draw_val;
            endcase
         end else begin
            color_ff[{cmd.idx[1:0], 3'b000} +: 8] <= interp_sat;
         end
      end
      if (cmd.rsp_load) begin
         rsp_led_out    <= led_ff;
         rsp_color      <= in_range_ff ? color_ff : 32'd0;
         rsp_retargeted <= retarget_ff;
      end
   end

   assign status.in_range   = in_range_ff;
   assign status.op_init    = op_ff == lrcf_pkg::OP_INIT;
   assign status.cnt_at_end = cnt_ff == ent_ff.end_tick;
   assign status.div_done   = div_done;

endmodule

@@ src/lrcf_ctrl.sv @@
// ----------------------------------------------------------------------------
// lrcf_ctrl
// Sequencer for one request: state read, four lane interpolations (advance),
// five draws (init or retarget), state write-back and response handoff.
// ----------------------------------------------------------------------------
module lrcf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  lrcf_pkg::status_type status,
   output lrcf_pkg::cmd_type    cmd,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_LOAD   = 7'b0000010,
      S_MUL    = 7'b0000100,
      S_DSTART = 7'b0001000,
      S_DWAIT  = 7'b0010000,
      S_WRITE  = 7'b0100000,
      S_RESP   = 7'b1000000
   } state_type;

   state_type   state_ff, state_in;
   logic        draw_ff, draw_in;
   logic [2:0]  idx_ff, idx_in;
   logic        rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in      = state_ff;
      draw_in       = draw_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      cmd           = '0;
      cmd.draw      = draw_ff;
      cmd.idx       = idx_ff;
      req_ready     = 1'b0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            idx_in   = '0;
            if (!status.in_range) begin
               state_in = S_RESP;
            end else if (status.op_init) begin
               cmd.retarget = 1'b1;
               draw_in      = 1'b1;
               state_in     = S_DSTART;
            end else begin
               draw_in  = 1'b0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DSTART;
         end
         S_DSTART: begin
            cmd.div_start = 1'b1;
            state_in      = S_DWAIT;
         end
         S_DWAIT: begin
            if (status.div_done) begin
               cmd.capture = 1'b1;
               if (draw_ff) begin
                  if (idx_ff == lrcf_pkg::DRAW_TICKS) begin
                     state_in = S_WRITE;
                  end else begin
                     idx_in   = idx_ff + 3'd1;
                     state_in = S_DSTART;
                  end
               end else if (idx_ff == lrcf_pkg::LAST_LANE) begin
                  // The count is compared before the fade restarts.
                  if (status.cnt_at_end) begin
                     cmd.retarget = 1'b1;
                     draw_in      = 1'b1;
                     idx_in       = '0;
                     state_in     = S_DSTART;
                  end else begin
                     state_in = S_WRITE;
                  end
               end else begin
                  idx_in   = idx_ff + 3'd1;
                  state_in = S_MUL;
               end
            end
         end
         S_WRITE: begin
            cmd.write = 1'b1;
            state_in  = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         draw_ff      <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         draw_ff      <= draw_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ src/led_random_color_fade_top.sv @@
// One request at a time; an LED index beyond the array goes straight to the
// response. Each division on the shared divider has a start and a result
// capture, and each interpolation lane also needs a product step.
// Synchronous active-high reset; per-LED state reads as its reset value
// until first written, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// led_random_color_fade_top
// Per-LED RGBW cross-fade engine with random retargeting.
// ----------------------------------------------------------------------------
module led_random_color_fade_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [5:0]  req_led,
   input  logic [31:0] req_rand_red,
   input  logic [31:0] req_rand_green,
   input  logic [31:0] req_rand_blue,
   input  logic [31:0] req_rand_white,
   input  logic [31:0] req_rand_ticks,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_led_out,
   output logic [31:0] rsp_color,
   output logic        rsp_retargeted,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   lrcf_pkg::cmd_type    cmd;
   lrcf_pkg::status_type status;

   lrcf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .cmd       (cmd),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready)
   );

   lrcf_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_op         (req_op),
      .req_led        (req_led),
      .req_rand_red   (req_rand_red),
      .req_rand_green (req_rand_green),
      .req_rand_blue  (req_rand_blue),
      .req_rand_white (req_rand_white),
      .req_rand_ticks (req_rand_ticks),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_led_out    (rsp_led_out),
      .rsp_color      (rsp_color),
      .rsp_retargeted (rsp_retargeted)
   );

endmodule
